// ----- design/assert_macros.svh -----
// assertion macros shared by wsg_shape and wsg_conv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wsg_pkg.sv -----
// shared types, constants and sine table of the waveform sample generator
`timescale 1ns / 1ps
package wsg_pkg;

    localparam int PERIOD_SAMPLES      = 256;
    localparam int REFERENCE_MV_DEF    = 3300;
    localparam int FULL_SCALE_CODE_DEF = 4095;

    localparam int PHASE_W = 8;
    localparam int MODE_W  = 2;
    localparam int AMP_W   = 12;
    localparam int DUTY_W  = 7;
    localparam int CODE_W  = 12;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int SINE_W     = 12;
    localparam int SINE_MID   = 2048;
    localparam int SINE_SHIFT = 11;
    localparam int PROD_W     = 26;
    localparam int TERM_W     = 13;
    localparam int MV_W       = 14;

    localparam int TRI_W       = 20;
    localparam int TRI_DIV     = PERIOD_SAMPLES / 2 - 1;
    localparam int TRI_SHIFT   = 20;
    localparam int TRI_RECIP   = (1 << TRI_SHIFT) / TRI_DIV;
    localparam int TRI_RECIP_W = 14;
    localparam int TRI_Q_W     = 13;

    localparam int DUTY_MAX   = 100;
    localparam int DUTY_ROUND = 50;
    localparam int SQ_W       = DUTY_W + PHASE_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_DC       = 2'd0,
        MODE_SINE     = 2'd1,
        MODE_TRIANGLE = 2'd2,
        MODE_SQUARE   = 2'd3
    } t_wave_mode;

    typedef enum logic [1:0] {
        REG_WAVE_MODE = 2'd0,
        REG_AMPLITUDE = 2'd1,
        REG_OFFSET    = 2'd2,
        REG_DUTY      = 2'd3
    } t_reg_idx;

    localparam t_wave_mode      RST_MODE = MODE_SINE;
    localparam logic [AMP_W-1:0]  RST_AMP  = 12'd1000;
    localparam logic [AMP_W-1:0]  RST_OFF  = 12'd1650;
    localparam logic [DUTY_W-1:0] RST_DUTY = 7'd50;

    typedef struct packed {
        t_wave_mode         mode;
        logic [AMP_W-1:0]   amp;
        logic [AMP_W-1:0]   off;
        logic [DUTY_W-1:0]  duty;
    } t_cfg;

    localparam logic [SINE_W-1:0] SINE_TAB [PERIOD_SAMPLES] = '{
        12'd2048, 12'd2098, 12'd2148, 12'd2198, 12'd2248, 12'd2298, 12'd2348, 12'd2398,
        12'd2447, 12'd2496, 12'd2545, 12'd2594, 12'd2642, 12'd2690, 12'd2737, 12'd2784,
        12'd2831, 12'd2877, 12'd2923, 12'd2968, 12'd3013, 12'd3057, 12'd3100, 12'd3143,
        12'd3185, 12'd3226, 12'd3267, 12'd3307, 12'd3346, 12'd3385, 12'd3423, 12'd3459,
        12'd3495, 12'd3530, 12'd3565, 12'd3598, 12'd3630, 12'd3662, 12'd3692, 12'd3722,
        12'd3750, 12'd3777, 12'd3804, 12'd3829, 12'd3853, 12'd3876, 12'd3898, 12'd3919,
        12'd3939, 12'd3958, 12'd3975, 12'd3992, 12'd4007, 12'd4021, 12'd4034, 12'd4045,
        12'd4056, 12'd4065, 12'd4073, 12'd4080, 12'd4085, 12'd4089, 12'd4093, 12'd4094,
        12'd4095, 12'd4094, 12'd4093, 12'd4089, 12'd4085, 12'd4080, 12'd4073, 12'd4065,
        12'd4056, 12'd4045, 12'd4034, 12'd4021, 12'd4007, 12'd3992, 12'd3975, 12'd3958,
        12'd3939, 12'd3919, 12'd3898, 12'd3876, 12'd3853, 12'd3829, 12'd3804, 12'd3777,
        12'd3750, 12'd3722, 12'd3692, 12'd3662, 12'd3630, 12'd3598, 12'd3565, 12'd3530,
        12'd3495, 12'd3459, 12'd3423, 12'd3385, 12'd3346, 12'd3307, 12'd3267, 12'd3226,
        12'd3185, 12'd3143, 12'd3100, 12'd3057, 12'd3013, 12'd2968, 12'd2923, 12'd2877,
        12'd2831, 12'd2784, 12'd2737, 12'd2690, 12'd2642, 12'd2594, 12'd2545, 12'd2496,
        12'd2447, 12'd2398, 12'd2348, 12'd2298, 12'd2248, 12'd2198, 12'd2148, 12'd2098,
        12'd2048, 12'd1997, 12'd1947, 12'd1897, 12'd1847, 12'd1797, 12'd1747, 12'd1697,
        12'd1648, 12'd1599, 12'd1550, 12'd1501, 12'd1453, 12'd1405, 12'd1358, 12'd1311,
        12'd1264, 12'd1218, 12'd1172, 12'd1127, 12'd1082, 12'd1038, 12'd995,  12'd952,
        12'd910,  12'd869,  12'd828,  12'd788,  12'd749,  12'd710,  12'd672,  12'd636,
        12'd600,  12'd565,  12'd530,  12'd497,  12'd465,  12'd433,  12'd403,  12'd373,
        12'd345,  12'd318,  12'd291,  12'd266,  12'd242,  12'd219,  12'd197,  12'd176,
        12'd156,  12'd137,  12'd120,  12'd103,  12'd88,   12'd74,   12'd61,   12'd50,
        12'd39,   12'd30,   12'd22,   12'd15,   12'd10,   12'd6,    12'd2,    12'd1,
        12'd0,    12'd1,    12'd2,    12'd6,    12'd10,   12'd15,   12'd22,   12'd30,
        12'd39,   12'd50,   12'd61,   12'd74,   12'd88,   12'd103,  12'd120,  12'd137,
        12'd156,  12'd176,  12'd197,  12'd219,  12'd242,  12'd266,  12'd291,  12'd318,
        12'd345,  12'd373,  12'd403,  12'd433,  12'd465,  12'd497,  12'd530,  12'd565,
        12'd600,  12'd636,  12'd672,  12'd710,  12'd749,  12'd788,  12'd828,  12'd869,
        12'd910,  12'd952,  12'd995,  12'd1038, 12'd1082, 12'd1127, 12'd1172, 12'd1218,
        12'd1264, 12'd1311, 12'd1358, 12'd1405, 12'd1453, 12'd1501, 12'd1550, 12'd1599,
        12'd1648, 12'd1697, 12'd1747, 12'd1797, 12'd1847, 12'd1897, 12'd1947, 12'd1997
    };

endpackage

// ----- design/waveform_sample_generator.sv -----
// top level of the waveform sample generator
`timescale 1ns / 1ps
// One phase index is taken on every clock where start is high and busy is low, and
// its DAC code appears on o_sample_code with o_clipped, marked by o_done for one cycle.
// One transfer is taken per clock while busy is low; the path is a fixed pipeline
// (sine memory read, a multiplier shared by the sine and triangle modes, level and
// saturation stages, then a four-stage reciprocal divider for the code conversion).
// After reset busy stays high while the sine table memory is loaded; registers may
// be written meanwhile. Results cannot be held off, so the receiver must take every
// o_done transfer in its cycle. Write registers only while no transfer is in flight.
module waveform_sample_generator import wsg_pkg::*; #(
    parameter int REFERENCE_MV    = REFERENCE_MV_DEF,
    parameter int FULL_SCALE_CODE = FULL_SCALE_CODE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [PHASE_W-1:0] i_phase_index,
    output logic               o_done,
    output logic [CODE_W-1:0]  o_sample_code,
    output logic               o_clipped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int MVC_W = $clog2(REFERENCE_MV + 1);

    t_cfg             w_cfg;
    logic             w_lvl_vld;
    logic [MVC_W-1:0] w_lvl_mv;
    logic             w_lvl_clip;

    wsg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wsg_shape #(
        .REFERENCE_MV (REFERENCE_MV)
    ) u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_phase (i_phase_index),
        .i_cfg   (w_cfg),
        .o_vld   (w_lvl_vld),
        .o_mv    (w_lvl_mv),
        .o_clip  (w_lvl_clip)
    );

    wsg_conv #(
        .REFERENCE_MV    (REFERENCE_MV),
        .FULL_SCALE_CODE (FULL_SCALE_CODE)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_lvl_vld),
        .i_mv    (w_lvl_mv),
        .i_clip  (w_lvl_clip),
        .o_vld   (o_done),
        .o_code  (o_sample_code),
        .o_clip  (o_clipped)
    );

endmodule

// ----- design/wsg_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module wsg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/wsg_cfg.sv -----
// apb configuration registers
`timescale 1ns / 1ps
module wsg_cfg import wsg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_WAVE_MODE: n_cfg.mode = t_wave_mode'(pwdata[MODE_W-1:0]);
                REG_AMPLITUDE: n_cfg.amp  = pwdata[AMP_W-1:0];
                REG_OFFSET:    n_cfg.off  = pwdata[AMP_W-1:0];
                REG_DUTY:      n_cfg.duty = pwdata[DUTY_W-1:0];
                default:       n_cfg      = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= RST_MODE;
            r_cfg.amp  <= RST_AMP;
            r_cfg.off  <= RST_OFF;
            r_cfg.duty <= RST_DUTY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WAVE_MODE: prdata = DATA_W'(r_cfg.mode);
            REG_AMPLITUDE: prdata = DATA_W'(r_cfg.amp);
            REG_OFFSET:    prdata = DATA_W'(r_cfg.off);
            REG_DUTY:      prdata = DATA_W'(r_cfg.duty);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/wsg_shape.sv -----
// sine table memory with load sequencer and millivolt level pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsg_shape import wsg_pkg::*; #(
    parameter int REFERENCE_MV = REFERENCE_MV_DEF,
    localparam int MVC_W       = $clog2(REFERENCE_MV + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [PHASE_W-1:0] i_phase,
    input  t_cfg               i_cfg,
    output logic               o_vld,
    output logic [MVC_W-1:0]   o_mv,
    output logic               o_clip
);

    // table load sequencer
    logic [PHASE_W:0]   r_fill_idx;
    logic               w_filling;
    logic               w_accept;
    logic [SINE_W-1:0]  w_sine;

    assign w_filling = !r_fill_idx[PHASE_W];
    assign w_accept  = i_start & !w_filling;
    assign o_busy    = w_filling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_idx <= '0;
        end else if (w_filling) begin
            r_fill_idx <= r_fill_idx + 1'b1;
        end
    end

    wsg_ram #(
        .WIDTH (SINE_W),
        .DEPTH (PERIOD_SAMPLES)
    ) u_sine_ram (
        .i_clk   (i_clk),
        .i_we    (w_filling),
        .i_waddr (r_fill_idx[PHASE_W-1:0]),
        .i_wdata (SINE_TAB[r_fill_idx[PHASE_W-1:0]]),
        .i_re    (w_accept),
        .i_raddr (i_phase),
        .o_rdata (w_sine)
    );

    // stage a: table word available
    logic               r_a_vld;
    logic [PHASE_W-1:0] r_a_phase;
    logic signed [SINE_W:0]   w_opnd;
    logic signed [SINE_W:0]   w_amp_s;
    logic signed [PROD_W-1:0] w_prod;
    logic [DUTY_W-1:0]  w_duty;
    logic [PHASE_W:0]   w_phase1;
    logic [SQ_W-1:0]    w_sq_lhs;
    logic [SQ_W-1:0]    w_sq_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_phase <= i_phase;
        end
    end

    always_comb begin
        w_amp_s = $signed({1'b0, i_cfg.amp});
        if (i_cfg.mode == MODE_SINE) begin
            w_opnd = $signed({1'b0, w_sine}) - $signed((SINE_W + 1)'(SINE_MID));
        end else begin
            w_opnd = $signed({{(SINE_W - PHASE_W + 1){1'b0}},
                              r_a_phase[PHASE_W-2:0], 1'b0});
        end
        w_prod   = w_opnd * w_amp_s;
        w_duty   = (i_cfg.duty > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : i_cfg.duty;
        w_phase1 = {1'b0, r_a_phase} + 1'b1;
        w_sq_lhs = SQ_W'(SQ_W'(w_phase1) * SQ_W'(DUTY_MAX));
        w_sq_rhs = {w_duty, {PHASE_W{1'b0}}} + SQ_W'(DUTY_ROUND);
    end

    // stage b: product registered
    logic                     r_b_vld;
    logic signed [PROD_W-1:0] r_b_prod;
    logic                     r_b_upper;
    logic                     r_b_sq_hi;
    logic signed [PROD_W-1:0] w_sine_adj;
    logic signed [TERM_W-1:0] w_sine_s;
    logic [TRI_W-1:0]         w_tri_p;
    logic [TRI_W+TRI_RECIP_W-1:0] w_tri_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_prod  <= w_prod;
        r_b_upper <= r_a_phase[PHASE_W-1];
        r_b_sq_hi <= (w_sq_lhs <= w_sq_rhs);
    end

    always_comb begin
        // truncate toward zero
        w_sine_adj = r_b_prod + (r_b_prod[PROD_W-1] ? PROD_W'(SINE_MID - 1) : PROD_W'(0));
        w_sine_s   = TERM_W'(w_sine_adj >>> SINE_SHIFT);
        w_tri_p    = r_b_prod[TRI_W-1:0];
        w_tri_m    = (TRI_W + TRI_RECIP_W)'(w_tri_p) * (TRI_W + TRI_RECIP_W)'(TRI_RECIP);
    end

    // stage c: scaled values
    logic                     r_c_vld;
    logic signed [TERM_W-1:0] r_c_sine;
    logic [TRI_W-1:0]         r_c_tri_p;
    logic [TRI_Q_W-1:0]       r_c_tri_q0;
    logic                     r_c_upper;
    logic                     r_c_sq_hi;
    logic [TRI_W-1:0]         w_tri_back;
    logic [TRI_W-1:0]         w_tri_rem;
    logic [TRI_Q_W-1:0]       w_tri_q;
    logic signed [MV_W-1:0]   w_amp_m;
    logic signed [MV_W-1:0]   w_tri_qs;
    logic signed [TERM_W-1:0] w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_sine   <= w_sine_s;
        r_c_tri_p  <= w_tri_p;
        r_c_tri_q0 <= w_tri_m[TRI_SHIFT +: TRI_Q_W];
        r_c_upper  <= r_b_upper;
        r_c_sq_hi  <= r_b_sq_hi;
    end

    always_comb begin
        w_tri_back = TRI_W'(TRI_W'(r_c_tri_q0) * TRI_W'(TRI_DIV));
        w_tri_rem  = r_c_tri_p - w_tri_back;
        w_tri_q    = r_c_tri_q0 + TRI_Q_W'(w_tri_rem >= TRI_W'(TRI_DIV));
        w_amp_m    = $signed(MV_W'(i_cfg.amp));
        w_tri_qs   = $signed(MV_W'(w_tri_q));
        case (i_cfg.mode)
            MODE_DC:       w_term = '0;
            MODE_SINE:     w_term = r_c_sine;
            MODE_TRIANGLE: w_term = r_c_upper ? TERM_W'(w_amp_m - w_tri_qs)
                                              : TERM_W'(w_tri_qs - w_amp_m);
            MODE_SQUARE:   w_term = r_c_sq_hi ? TERM_W'(w_amp_m) : TERM_W'(-w_amp_m);
            default:       w_term = '0;
        endcase
    end

    // stage d: level term
    logic                     r_d_vld;
    logic signed [TERM_W-1:0] r_d_term;
    logic signed [MV_W-1:0]   w_mv;
    logic [MVC_W-1:0]         w_mv_sat;
    logic                     w_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_term <= w_term;
    end

    always_comb begin
        w_mv = $signed(MV_W'(i_cfg.off)) + MV_W'(r_d_term);
        if (w_mv < 0) begin
            w_mv_sat = '0;
            w_clip   = 1'b1;
        end else if (w_mv > $signed(MV_W'(REFERENCE_MV))) begin
            w_mv_sat = MVC_W'(REFERENCE_MV);
            w_clip   = 1'b1;
        end else begin
            w_mv_sat = MVC_W'(w_mv);
            w_clip   = 1'b0;
        end
    end

    // stage e: saturated level
    logic             r_e_vld;
    logic [MVC_W-1:0] r_e_mv;
    logic             r_e_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_mv   <= w_mv_sat;
        r_e_clip <= w_clip;
    end

    assign o_vld  = r_e_vld;
    assign o_mv   = r_e_mv;
    assign o_clip = r_e_clip;

    `ASSERT_NEXT(a_no_issue_during_load, i_clk, i_rst_n, w_filling, !r_a_vld, "item issued during table load")
    `ASSERT_IMPL(a_clip_at_rail, i_clk, i_rst_n, r_e_vld && r_e_clip, r_e_mv == '0 || r_e_mv == MVC_W'(REFERENCE_MV), "clipped level not at a rail")

endmodule

// ----- design/wsg_conv.sv -----
// millivolt to dac code conversion with rounding
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsg_conv import wsg_pkg::*; #(
    parameter int REFERENCE_MV    = REFERENCE_MV_DEF,
    parameter int FULL_SCALE_CODE = FULL_SCALE_CODE_DEF,
    localparam int MVC_W          = $clog2(REFERENCE_MV + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [MVC_W-1:0]  i_mv,
    input  logic              i_clip,
    output logic              o_vld,
    output logic [CODE_W-1:0] o_code,
    output logic              o_clip
);

    localparam int X_W      = $clog2(REFERENCE_MV * FULL_SCALE_CODE + REFERENCE_MV / 2 + 1);
    localparam int SHIFT    = X_W + 1;
    localparam longint RECIP = (longint'(1) << SHIFT) / REFERENCE_MV;
    localparam int M_W      = $clog2(RECIP + 1);
    localparam int XL_W     = X_W / 2;
    localparam int XH_W     = X_W - XL_W;
    localparam int PL_W     = XL_W + M_W;
    localparam int PH_W     = XH_W + M_W;
    localparam int Q_W      = $clog2(FULL_SCALE_CODE + 1) + 1;
    localparam int SUM_A    = X_W + M_W + 1;
    localparam int SUM_W    = (SUM_A > SHIFT + Q_W) ? SUM_A : SHIFT + Q_W;

    // stage 1: scaled numerator
    logic           r1_vld;
    logic [X_W-1:0] r1_x;
    logic           r1_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x    <= X_W'(X_W'(i_mv) * X_W'(FULL_SCALE_CODE)) + X_W'(REFERENCE_MV / 2);
        r1_clip <= i_clip;
    end

    // stage 2: reciprocal partial products
    logic            r2_vld;
    logic [PL_W-1:0] r2_pl;
    logic [PH_W-1:0] r2_ph;
    logic [X_W-1:0]  r2_x;
    logic            r2_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pl   <= PL_W'(r1_x[XL_W-1:0]) * PL_W'(RECIP);
        r2_ph   <= PH_W'(r1_x[X_W-1:XL_W]) * PH_W'(RECIP);
        r2_x    <= r1_x;
        r2_clip <= r1_clip;
    end

    // stage 3: quotient estimate
    logic             r3_vld;
    logic [Q_W-1:0]   r3_q0;
    logic [X_W-1:0]   r3_x;
    logic             r3_clip;
    logic [SUM_W-1:0] w_sum;

    assign w_sum = (SUM_W'(r2_ph) << XL_W) + SUM_W'(r2_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_q0   <= w_sum[SHIFT +: Q_W];
        r3_x    <= r2_x;
        r3_clip <= r2_clip;
    end

    // stage 4: one-step correction
    logic              r4_vld;
    logic [CODE_W-1:0] r4_code;
    logic              r4_clip;
    logic [X_W-1:0]    w_back;
    logic [X_W-1:0]    w_rem;
    logic [Q_W-1:0]    w_q;

    always_comb begin
        w_back = X_W'(X_W'(r3_q0) * X_W'(REFERENCE_MV));
        w_rem  = r3_x - w_back;
        w_q    = r3_q0 + Q_W'(w_rem >= X_W'(REFERENCE_MV));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_code <= CODE_W'(w_q);
        r4_clip <= r3_clip;
    end

    assign o_vld  = r4_vld;
    assign o_code = r4_code;
    assign o_clip = r4_clip;

    `ASSERT_IMPL(a_rem_in_range, i_clk, i_rst_n, r3_vld, w_rem < X_W'(2 * REFERENCE_MV), "quotient estimate off by more than one")
    `ASSERT_IMPL(a_no_extra, i_clk, i_rst_n, r4_vld, $past(i_vld, 4), "invented transfer")
    `ASSERT_IMPL(a_no_loss, i_clk, i_rst_n, i_vld, ##4 r4_vld, "lost transfer")

endmodule

// ----- test/testbench.sv -----
// self-checking testbench of the waveform sample generator: directed table, then random phases
`timescale 1ns / 1ps
module testbench;
    import wsg_pkg::*;

    localparam int N_RANDOM    = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;
    localparam int HALF        = PERIOD_SAMPLES / 2;
    localparam int REF_MV      = REFERENCE_MV_DEF;
    localparam int FULL_CODE   = FULL_SCALE_CODE_DEF;
    localparam int N_DIRECTED  = 24;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              clip;
    } sample_t;

    typedef struct packed {
        bit                 wr;
        logic [31:0]        mode_w;
        logic [31:0]        amp_w;
        logic [31:0]        off_w;
        logic [31:0]        duty_w;
        logic [PHASE_W-1:0] ph;
        bit                 typed;
        logic [CODE_W-1:0]  code;
        bit                 clip;
    } dir_row_t;

    localparam logic [SINE_W-1:0] SINE_REF [PERIOD_SAMPLES] = '{
        2048, 2098, 2148, 2198, 2248, 2298, 2348, 2398, 2447, 2496, 2545, 2594, 2642, 2690,
        2737, 2784, 2831, 2877, 2923, 2968, 3013, 3057, 3100, 3143, 3185, 3226, 3267, 3307,
        3346, 3385, 3423, 3459, 3495, 3530, 3565, 3598, 3630, 3662, 3692, 3722, 3750, 3777,
        3804, 3829, 3853, 3876, 3898, 3919, 3939, 3958, 3975, 3992, 4007, 4021, 4034, 4045,
        4056, 4065, 4073, 4080, 4085, 4089, 4093, 4094, 4095, 4094, 4093, 4089, 4085, 4080,
        4073, 4065, 4056, 4045, 4034, 4021, 4007, 3992, 3975, 3958, 3939, 3919, 3898, 3876,
        3853, 3829, 3804, 3777, 3750, 3722, 3692, 3662, 3630, 3598, 3565, 3530, 3495, 3459,
        3423, 3385, 3346, 3307, 3267, 3226, 3185, 3143, 3100, 3057, 3013, 2968, 2923, 2877,
        2831, 2784, 2737, 2690, 2642, 2594, 2545, 2496, 2447, 2398, 2348, 2298, 2248, 2198,
        2148, 2098, 2048, 1997, 1947, 1897, 1847, 1797, 1747, 1697, 1648, 1599, 1550, 1501,
        1453, 1405, 1358, 1311, 1264, 1218, 1172, 1127, 1082, 1038, 995, 952, 910, 869,
        828, 788, 749, 710, 672, 636, 600, 565, 530, 497, 465, 433, 403, 373,
        345, 318, 291, 266, 242, 219, 197, 176, 156, 137, 120, 103, 88, 74,
        61, 50, 39, 30, 22, 15, 10, 6, 2, 1, 0, 1, 2, 6,
        10, 15, 22, 30, 39, 50, 61, 74, 88, 103, 120, 137, 156, 176,
        197, 219, 242, 266, 291, 318, 345, 373, 403, 433, 465, 497, 530, 565,
        600, 636, 672, 710, 749, 788, 828, 869, 910, 952, 995, 1038, 1082, 1127,
        1172, 1218, 1264, 1311, 1358, 1405, 1453, 1501, 1550, 1599, 1648, 1697, 1747, 1797,
        1847, 1897, 1947, 1997
    };

    // wr, mode, amplitude, offset, duty, phase, typed, code, clip
    dir_row_t dir_rows [N_DIRECTED] = '{
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 1'b1, 12'd2048, 1'b0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd64, 1'b0, 12'd0, 1'b0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd192, 1'b0, 12'd0, 1'b0},
        '{1'b1, 32'(MODE_DC), 32'd0, 32'd0, 32'd0, 8'd0, 1'b1, 12'd0, 1'b0},
        '{1'b1, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h8000_0CE4, 32'hFFFF_FFFF, 8'd255,
          1'b1, 12'd4095, 1'b0},
        '{1'b1, 32'(MODE_DC), 32'd0, 32'd4095, 32'd50, 8'd17, 1'b1, 12'd4095, 1'b1},
        '{1'b1, 32'(MODE_DC), 32'd0, 32'd3301, 32'd50, 8'd1, 1'b1, 12'd4095, 1'b1},
        '{1'b1, 32'(MODE_SINE), 32'd3300, 32'd0, 32'd50, 8'd192, 1'b1, 12'd0, 1'b1},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd64, 1'b0, 12'd0, 1'b0},
        '{1'b1, 32'(MODE_SINE), 32'd4095, 32'd4095, 32'd50, 8'd0, 1'b1, 12'd4095, 1'b1},
        '{1'b1, 32'(MODE_SINE), 32'd0, 32'd1650, 32'd50, 8'd100, 1'b1, 12'd2048, 1'b0},
        '{1'b1, 32'(MODE_TRIANGLE), 32'd3300, 32'd1650, 32'd50, 8'd0, 1'b1, 12'd0, 1'b1},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd127, 1'b1, 12'd4095, 1'b1},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd128, 1'b1, 12'd4095, 1'b1},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd255, 1'b1, 12'd0, 1'b1},
        '{1'b1, 32'(MODE_TRIANGLE), 32'd1000, 32'd1650, 32'd50, 8'd64, 1'b0, 12'd0, 1'b0},
        '{1'b1, 32'(MODE_SQUARE), 32'd1650, 32'd1650, 32'd0, 8'd0, 1'b1, 12'd0, 1'b0},
        '{1'b1, 32'(MODE_SQUARE), 32'd1650, 32'd1650, 32'd100, 8'd255, 1'b1, 12'd4095, 1'b0},
        '{1'b1, 32'(MODE_SQUARE), 32'd1650, 32'd1650, 32'd127, 8'd255, 1'b1, 12'd4095, 1'b0},
        '{1'b1, 32'(MODE_SQUARE), 32'd1650, 32'd1650, 32'd50, 8'd127, 1'b1, 12'd4095, 1'b0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd128, 1'b1, 12'd0, 1'b0},
        '{1'b1, 32'(MODE_SQUARE), 32'd1000, 32'd2000, 32'd1, 8'd2, 1'b0, 12'd0, 1'b0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd3, 1'b0, 12'd0, 1'b0},
        '{1'b1, 32'h0000_0005, 32'd1000, 32'd1650, 32'd50, 8'd32, 1'b0, 12'd0, 1'b0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [PHASE_W-1:0] i_phase_index;
    logic               o_done;
    logic [CODE_W-1:0]  o_sample_code;
    logic               o_clipped;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    t_cfg    cfg_now;
    sample_t pending_samples [$];
    sample_t got_sample;
    int      n_mismatch;
    int      n_cycles;

    waveform_sample_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_phase_index (i_phase_index),
        .o_done        (o_done),
        .o_sample_code (o_sample_code),
        .o_clipped     (o_clipped),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic sample_t dac_sample(logic [PHASE_W-1:0] ph);
        int      amp;
        int      off;
        int      idx;
        int      mv;
        int      duty;
        int      high_cnt;
        sample_t s;
        amp = int'(cfg_now.amp);
        off = int'(cfg_now.off);
        idx = int'(ph);
        case (cfg_now.mode)
            MODE_DC: begin
                mv = off;
            end
            MODE_SINE: begin
                mv = off + ((int'(SINE_REF[idx]) - SINE_MID) * amp) / SINE_MID;
            end
            MODE_TRIANGLE: begin
                if (idx < HALF) begin
                    mv = off - amp + (2 * amp * idx) / (HALF - 1);
                end else begin
                    mv = off + amp - (2 * amp * (idx - HALF)) / (HALF - 1);
                end
            end
            default: begin
                duty = (int'(cfg_now.duty) > DUTY_MAX) ? DUTY_MAX : int'(cfg_now.duty);
                high_cnt = (duty * PERIOD_SAMPLES + DUTY_ROUND) / DUTY_MAX;
                mv = (idx < high_cnt) ? off + amp : off - amp;
            end
        endcase
        s.clip = 1'b0;
        if (mv < 0) begin
            mv = 0;
            s.clip = 1'b1;
        end else if (mv > REF_MV) begin
            mv = REF_MV;
            s.clip = 1'b1;
        end
        s.code = CODE_W'((mv * FULL_CODE + REF_MV / 2) / REF_MV);
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(t_reg_idx r);
        case (r)
            REG_WAVE_MODE: return DATA_W'(cfg_now.mode);
            REG_AMPLITUDE: return DATA_W'(cfg_now.amp);
            REG_OFFSET:    return DATA_W'(cfg_now.off);
            default:       return DATA_W'(cfg_now.duty);
        endcase
    endfunction

    task automatic flag_mismatch(string what, int want_v, int got_v);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want_v, got_v, $realtime);
        end
    endtask

    task automatic write_reg(t_reg_idx r, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({r, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (r)
            REG_WAVE_MODE: cfg_now.mode = t_wave_mode'(data[MODE_W-1:0]);
            REG_AMPLITUDE: cfg_now.amp  = data[AMP_W-1:0];
            REG_OFFSET:    cfg_now.off  = data[AMP_W-1:0];
            default:       cfg_now.duty = data[DUTY_W-1:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        logic [DATA_W-1:0] rd;
        t_reg_idx          r;
        for (int i = 0; i < 4; i++) begin
            r = t_reg_idx'(i);
            @(negedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= ADDR_W'({r, 2'b00});
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            rd = prdata;
            if (rd !== reg_value(r)) begin
                flag_mismatch($sformatf("register %s", r.name()), int'(reg_value(r)), int'(rd));
            end
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // start stays high after a transfer until the next falling edge decides
    task automatic send_phase(logic [PHASE_W-1:0] ph, int gap, sample_t want);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_phase_index <= ph;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_samples.push_back(want);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [DATA_W-1:0] w;
        int                v;
        if ($urandom_range(0, 3) != 0) begin
            w = $urandom();
            w[MODE_W-1:0] = MODE_W'($urandom_range(0, 3));
            write_reg(REG_WAVE_MODE, w);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0: v = 0;
                1: v = REF_MV;
                2: v = 4095;
                3: v = $urandom_range(1, 50);
                4: v = $urandom_range(0, 4095);
                default: v = $urandom_range(0, 1650);
            endcase
            w = $urandom();
            w[AMP_W-1:0] = AMP_W'(v);
            write_reg(REG_AMPLITUDE, w);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0: v = 0;
                1: v = REF_MV;
                2: v = 4095;
                3: v = REF_MV + 1;
                4: v = $urandom_range(0, 4095);
                default: v = $urandom_range(1000, 2300);
            endcase
            w = $urandom();
            w[AMP_W-1:0] = AMP_W'(v);
            write_reg(REG_OFFSET, w);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0: v = 0;
                1: v = DUTY_MAX;
                2: v = 127;
                3: v = $urandom_range(DUTY_MAX + 1, 127);
                default: v = $urandom_range(0, DUTY_MAX);
            endcase
            w = $urandom();
            w[DUTY_W-1:0] = DUTY_W'(v);
            write_reg(REG_DUTY, w);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_samples.size() == 0) begin
                flag_mismatch("unexpected transfer, code", -1, int'(o_sample_code));
            end else begin
                got_sample = pending_samples.pop_front();
                if (o_sample_code !== got_sample.code) begin
                    flag_mismatch("sample_code", int'(got_sample.code), int'(o_sample_code));
                end
                if (o_clipped !== got_sample.clip) begin
                    flag_mismatch("clipped", int'(got_sample.clip), int'(o_clipped));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL waveform_sample_generator");
            $finish;
        end
    end

    initial begin
        sample_t            typed_s;
        logic [PHASE_W-1:0] ph;
        int                 n_sent;
        int                 len;
        int                 step;
        bit                 burst;
        bit                 sweep;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_phase_index = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        n_mismatch    = 0;
        n_cycles      = 0;
        n_sent        = 0;
        cfg_now.mode  = RST_MODE;
        cfg_now.amp   = RST_AMP;
        cfg_now.off   = RST_OFF;
        cfg_now.duty  = RST_DUTY;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_registers();

        foreach (dir_rows[i]) begin
            if (dir_rows[i].wr) begin
                wait_drained();
                write_reg(REG_WAVE_MODE, dir_rows[i].mode_w);
                write_reg(REG_AMPLITUDE, dir_rows[i].amp_w);
                write_reg(REG_OFFSET, dir_rows[i].off_w);
                write_reg(REG_DUTY, dir_rows[i].duty_w);
            end
            typed_s.code = dir_rows[i].code;
            typed_s.clip = dir_rows[i].clip;
            send_phase(dir_rows[i].ph, $urandom_range(0, 15),
                       dir_rows[i].typed ? typed_s : dac_sample(dir_rows[i].ph));
        end

        while (n_sent < N_RANDOM) begin
            wait_drained();
            random_config();
            check_registers();
            burst = ($urandom_range(0, 3) == 0);
            sweep = ($urandom_range(0, 1) == 1);
            step  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : 1;
            ph    = PHASE_W'($urandom());
            len   = $urandom_range(10, 60);
            repeat (len) begin
                send_phase(ph, burst ? 0 : $urandom_range(0, 15), dac_sample(ph));
                ph = sweep ? ph + PHASE_W'(step) : PHASE_W'($urandom());
                n_sent++;
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("PASS waveform_sample_generator");
        end else begin
            $display("FAIL waveform_sample_generator");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/wsg_pkg.sv
design/wsg_ram.sv
design/wsg_cfg.sv
design/wsg_shape.sv
design/wsg_conv.sv
design/waveform_sample_generator.sv
test/testbench.sv
